### src/pttt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pttt_pkg
// Shared types and constants for the periodic task timer table.
// ----------------------------------------------------------------------------
package pttt_pkg;

    localparam int TASK_W    = 8;
    localparam int HANDLER_W = 8;
    localparam int PERIOD_W  = 16;
    localparam int ENTRY_W   = TASK_W + HANDLER_W + 2 * PERIOD_W;

    typedef enum logic [1:0] {
        K_START = 2'd0,
        K_STOP  = 2'd1,
        K_TICK  = 2'd2,
        K_NONE  = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_NOT_ENABLED  = 3'd1,
        ST_FULL         = 3'd2,
        ST_NULL_HANDLER = 3'd3,
        ST_DUPLICATE    = 3'd4,
        ST_NOT_FOUND    = 3'd5
    } status_t;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_READ = 5'b00010,
        S_EVAL = 5'b00100,
        S_FIN  = 5'b01000,
        S_DONE = 5'b10000
    } state_t;

endpackage

### src/pttt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pttt_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module pttt_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 8
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### src/periodic_task_timer_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_task_timer_table
// Table of periodic tasks with start, stop and tick commands.
// ----------------------------------------------------------------------------
// Every command but a rejected start walks the table one entry at a time
// through a RAM with one write and one registered read port: each entry
// takes a read state, then an evaluate state (compare, or count down with
// write-back). A start then writes its entry unless it is a duplicate, a
// stop ends at the first match, and a tick can hold while the output is
// stalled. One beat is in flight at a time; in_stall is high while a
// command is being worked. A tick gives one result beat per expiring task,
// the final one with last set, and none when no task expires. Entries need
// no clearing after reset.
// ----------------------------------------------------------------------------
module periodic_task_timer_table
    import pttt_pkg::*;
#(
    parameter int TABLE_DEPTH = 8
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  kind,
    input  logic [7:0]  task_id,
    input  logic [7:0]  handler_id,
    input  logic [15:0] period,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic        fired,
    output logic [7:0]  fired_task_id,
    output logic [7:0]  fired_handler_id,
    output logic        last,
    output logic [3:0]  active_count
);

    localparam int IDX_W = TABLE_DEPTH > 1 ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    // control state
    state_t                 state_reg,      state_next;
    logic                   enabled_reg,    enabled_next;
    logic [TABLE_DEPTH-1:0] used_reg,       used_next;
    logic [CNT_W-1:0]       count_reg,      count_next;
    logic [IDX_W-1:0]       idx_reg,        idx_next;
    logic                   dup_reg,        dup_next;
    logic                   free_found_reg, free_found_next;
    logic                   pend_valid_reg, pend_valid_next;
    logic                   out_valid_reg,  out_valid_next;

    // payload
    kind_t                  kind_reg,       kind_next;
    logic [TASK_W-1:0]      tid_reg,        tid_next;
    logic [HANDLER_W-1:0]   hid_reg,        hid_next;
    logic [PERIOD_W-1:0]    per_reg,        per_next;
    logic [IDX_W-1:0]       free_idx_reg,   free_idx_next;
    status_t                res_status_reg, res_status_next;
    logic [TASK_W-1:0]      pend_tid_reg,   pend_tid_next;
    logic [HANDLER_W-1:0]   pend_hid_reg,   pend_hid_next;
    status_t                status_reg,     status_next;
    logic                   fired_reg,      fired_next;
    logic [TASK_W-1:0]      ftid_reg,       ftid_next;
    logic [HANDLER_W-1:0]   fhid_reg,       fhid_next;
    logic                   last_reg,       last_next;
    logic [3:0]             acnt_reg,       acnt_next;

    // table ram
    logic                   ram_we;
    logic [IDX_W-1:0]       ram_waddr;
    logic [ENTRY_W-1:0]     ram_wdata;
    logic                   ram_re;
    logic [ENTRY_W-1:0]     ram_rdata;

    logic [TASK_W-1:0]      rd_task;
    logic [HANDLER_W-1:0]   rd_handler;
    logic [PERIOD_W-1:0]    rd_period;
    logic [PERIOD_W-1:0]    rd_count;
    logic [PERIOD_W-1:0]    reload;
    logic [PERIOD_W-1:0]    per_fixed;
    logic                   slot_used;
    logic                   key_match;
    logic                   expire;
    logic                   idx_last;
    logic                   out_free;
    logic [CNT_W+3:0]       count_ext;

    pttt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    assign rd_task    = ram_rdata[ENTRY_W-1 -: TASK_W];
    assign rd_handler = ram_rdata[2*PERIOD_W +: HANDLER_W];
    assign rd_period  = ram_rdata[PERIOD_W +: PERIOD_W];
    assign rd_count   = ram_rdata[0 +: PERIOD_W];

    assign slot_used = used_reg[idx_reg];
    assign key_match = (rd_task == tid_reg) && (rd_handler == hid_reg);
    assign expire    = rd_count <= PERIOD_W'(1);
    assign reload    = (rd_period == '0) ? PERIOD_W'(1) : rd_period;
    assign per_fixed = (per_reg == '0) ? PERIOD_W'(1) : per_reg;
    assign idx_last  = idx_reg == IDX_W'(TABLE_DEPTH - 1);
    assign out_free  = !out_valid_reg || !out_stall;
    assign count_ext = {4'b0, count_reg};

    always_comb
    begin
        state_next      = state_reg;
        enabled_next    = enabled_reg;
        used_next       = used_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        dup_next        = dup_reg;
        free_found_next = free_found_reg;
        pend_valid_next = pend_valid_reg;
        out_valid_next  = out_valid_reg && out_stall;
        kind_next       = kind_reg;
        tid_next        = tid_reg;
        hid_next        = hid_reg;
        per_next        = per_reg;
        free_idx_next   = free_idx_reg;
        res_status_next = res_status_reg;
        pend_tid_next   = pend_tid_reg;
        pend_hid_next   = pend_hid_reg;
        status_next     = status_reg;
        fired_next      = fired_reg;
        ftid_next       = ftid_reg;
        fhid_next       = fhid_reg;
        last_next       = last_reg;
        acnt_next       = acnt_reg;
        ram_we          = 1'b0;
        ram_waddr       = idx_reg;
        ram_wdata       = {rd_task, rd_handler, rd_period,
                           expire ? reload : rd_count - PERIOD_W'(1)};
        ram_re          = 1'b0;

        if (cfg_valid)
        begin
            enabled_next = cfg_data;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    kind_next       = kind_t'(kind);
                    tid_next        = task_id;
                    hid_next        = handler_id;
                    per_next        = period;
                    idx_next        = '0;
                    dup_next        = 1'b0;
                    free_found_next = 1'b0;
                    pend_valid_next = 1'b0;
                    case (kind_t'(kind))
                        K_START:
                        begin
                            if (!enabled_reg)
                            begin
                                res_status_next = ST_NOT_ENABLED;
                                state_next      = S_DONE;
                            end
                            else if (count_reg >= CNT_W'(TABLE_DEPTH))
                            begin
                                res_status_next = ST_FULL;
                                state_next      = S_DONE;
                            end
                            else if (handler_id == '0)
                            begin
                                res_status_next = ST_NULL_HANDLER;
                                state_next      = S_DONE;
                            end
                            else
                            begin
                                state_next = S_READ;
                            end
                        end
                        K_STOP, K_TICK:
                        begin
                            state_next = S_READ;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_READ:
            begin
                ram_re     = 1'b1;
                state_next = S_EVAL;
            end

            S_EVAL:
            begin
                case (kind_reg)
                    K_START:
                    begin
                        if (slot_used && key_match)
                        begin
                            dup_next = 1'b1;
                        end
                        if (!slot_used && !free_found_reg)
                        begin
                            free_found_next = 1'b1;
                            free_idx_next   = idx_reg;
                        end
                        if (idx_last)
                        begin
                            state_next = S_FIN;
                        end
                        else
                        begin
                            idx_next   = idx_reg + IDX_W'(1);
                            state_next = S_READ;
                        end
                    end
                    K_STOP:
                    begin
                        if (slot_used && key_match)
                        begin
                            used_next[idx_reg] = 1'b0;
                            count_next         = count_reg - CNT_W'(1);
                            res_status_next    = ST_OK;
                            state_next         = S_DONE;
                        end
                        else if (idx_last)
                        begin
                            res_status_next = ST_NOT_FOUND;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            idx_next   = idx_reg + IDX_W'(1);
                            state_next = S_READ;
                        end
                    end
                    K_TICK:
                    begin
                        // an earlier firing still waits for the output register
                        if (!(slot_used && expire && pend_valid_reg && !out_free))
                        begin
                            if (slot_used)
                            begin
                                ram_we = 1'b1;
                                if (expire)
                                begin
                                    if (pend_valid_reg)
                                    begin
                                        out_valid_next = 1'b1;
                                        status_next    = ST_OK;
                                        fired_next     = 1'b1;
                                        ftid_next      = pend_tid_reg;
                                        fhid_next      = pend_hid_reg;
                                        last_next      = 1'b0;
                                        acnt_next      = count_ext[3:0];
                                    end
                                    pend_valid_next = 1'b1;
                                    pend_tid_next   = rd_task;
                                    pend_hid_next   = rd_handler;
                                end
                            end
                            if (idx_last)
                            begin
                                state_next = S_FIN;
                            end
                            else
                            begin
                                idx_next   = idx_reg + IDX_W'(1);
                                state_next = S_READ;
                            end
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end

            S_FIN:
            begin
                case (kind_reg)
                    K_START:
                    begin
                        if (dup_reg)
                        begin
                            res_status_next = ST_DUPLICATE;
                        end
                        else
                        begin
                            ram_we                  = 1'b1;
                            ram_waddr               = free_idx_reg;
                            ram_wdata               = {tid_reg, hid_reg, per_fixed, per_fixed};
                            used_next[free_idx_reg] = 1'b1;
                            count_next              = count_reg + CNT_W'(1);
                            res_status_next         = ST_OK;
                        end
                        state_next = S_DONE;
                    end
                    K_TICK:
                    begin
                        if (!pend_valid_reg)
                        begin
                            state_next = S_IDLE;
                        end
                        else if (out_free)
                        begin
                            out_valid_next  = 1'b1;
                            status_next     = ST_OK;
                            fired_next      = 1'b1;
                            ftid_next       = pend_tid_reg;
                            fhid_next       = pend_hid_reg;
                            last_next       = 1'b1;
                            acnt_next       = count_ext[3:0];
                            pend_valid_next = 1'b0;
                            state_next      = S_IDLE;
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end

            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = res_status_reg;
                    fired_next     = 1'b0;
                    ftid_next      = '0;
                    fhid_next      = '0;
                    last_next      = 1'b1;
                    acnt_next      = count_ext[3:0];
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            enabled_reg    <= 1'b0;
            used_reg       <= '0;
            count_reg      <= '0;
            idx_reg        <= '0;
            dup_reg        <= 1'b0;
            free_found_reg <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            kind_reg       <= K_NONE;
        end
        else
        begin
            state_reg      <= state_next;
            enabled_reg    <= enabled_next;
            used_reg       <= used_next;
            count_reg      <= count_next;
            idx_reg        <= idx_next;
            dup_reg        <= dup_next;
            free_found_reg <= free_found_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            kind_reg       <= kind_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tid_reg        <= tid_next;
        hid_reg        <= hid_next;
        per_reg        <= per_next;
        free_idx_reg   <= free_idx_next;
        res_status_reg <= res_status_next;
        pend_tid_reg   <= pend_tid_next;
        pend_hid_reg   <= pend_hid_next;
        status_reg     <= status_next;
        fired_reg      <= fired_next;
        ftid_reg       <= ftid_next;
        fhid_reg       <= fhid_next;
        last_reg       <= last_next;
        acnt_reg       <= acnt_next;
    end

    assign cfg_ready        = 1'b1;
    assign in_stall         = state_reg != S_IDLE;
    assign out_valid        = out_valid_reg;
    assign status           = status_reg;
    assign fired            = fired_reg;
    assign fired_task_id    = ftid_reg;
    assign fired_handler_id = fhid_reg;
    assign last             = last_reg;
    assign active_count     = acnt_reg;

    // occupancy counter tracks the used bits
    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == CNT_W'($countones(used_reg)))
        else $error("occupancy count out of step with used bits");

    // a pending firing only exists during a tick scan
    a_pend_tick_only: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> kind_reg == K_TICK)
        else $error("pending firing outside a tick");

    // a firing beat always carries ok status
    a_fired_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && fired_reg |-> status_reg == ST_OK)
        else $error("fired beat with non-ok status");

    // a start while disabled leaves the table alone
    a_reject_stable: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && kind == K_START && !enabled_reg
        |=> $stable(used_reg) ##1 $stable(used_reg))
        else $error("table changed by a rejected start");

    // only a tick can produce a beat without last
    a_last_tick: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !last_reg |-> fired_reg)
        else $error("non-final beat that is not a firing");

endmodule
